// ----- rtl/core/cpd_pkg.sv -----
package cpd_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int POINT_W = 2 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQD_W   = 2 * COORD_W;
    localparam int BEST_W  = 51;
    localparam int SQ_W    = 52;
    localparam int HALF_W  = 26;

    localparam logic [BEST_W-1:0] BEST_INIT = {BEST_W{1'b1}};

    // Input beat: one point
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_in_beat;

    // Output beat: one result per set
    typedef struct packed {
        logic [SQ_W-1:0]   min_dist_sq;
        logic [HALF_W-1:0] half_distance;
        logic              no_pair;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_anchor;
        logic sqrt_start;
        logic out_load;
        logic out_no_pair;
        logic clr_best;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic sqrt_done;
    } t_dp_sts;

endpackage

// ----- rtl/core/closest_pair_distance.sv -----
// Closest pair of points over a loaded set.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one point per beat,
// x and y signed with 8 fraction bits; last_point closes the set. Points
// are taken one per cycle and written to the point store. Up to
// MAX_POINTS are kept; further points of the same set are dropped, but
// their last_point flag still closes the set.
// After the last point the input stalls while every stored pair is
// walked, paced by the single read port of the store, then while the
// difference/square/minimum pipeline drains and the bit-serial square
// root runs.
// Output channel (o_out_valid / i_out_stall / o_out_data): one beat per
// set with the minimum squared distance, its floor root and no_pair.
// The result sits in an output register; loading of the next set begins
// at once, and a new result waits only while the previous one is stalled.
// Reset empties the set and drops any pending result; store contents are
// not cleared, as only entries written in the current set are read.
module closest_pair_distance #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cpd_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cpd_pkg::t_out_beat  o_out_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    cpd_pkg::t_dp_cmd w_cmd;
    cpd_pkg::t_dp_sts w_sts;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;

    cpd_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_in_data.last_point),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cmd        (w_cmd),
        .o_wr_addr    (w_wr_addr),
        .o_rd_addr    (w_rd_addr),
        .i_sts        (w_sts)
    );

    cpd_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .i_wr_addr  (w_wr_addr),
        .i_rd_addr  (w_rd_addr),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

// ----- rtl/core/cpd_ram.sv -----
module cpd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/cpd_isqrt.sv -----
module cpd_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpd_pkg::BEST_W-1:0]  i_value,
    output logic [cpd_pkg::HALF_W-1:0]  o_root,
    output logic                        o_done
);

    localparam int VW = cpd_pkg::BEST_W;

    logic          r_busy;
    logic          r_done;
    logic [VW-1:0] r_v;
    logic [VW-1:0] r_res;
    logic [VW-1:0] r_bit;
    logic [VW:0]   w_trial;
    logic          w_take;

    // Trial subtraction of one root bit
    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_v} >= w_trial);

    // Restoring root, one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= VW'(1) << (VW - 1);
        end else if (r_busy) begin
            if (w_take) begin
                r_v   <= r_v - w_trial[VW-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[cpd_pkg::HALF_W-1:0];
    assign o_done = r_done;

endmodule

// ----- rtl/core/cpd_dp.sv -----
module cpd_dp #(
    parameter int MAX_POINTS = 1024,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpd_pkg::t_in_beat   i_in_data,
    input  cpd_pkg::t_dp_cmd    i_cmd,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [AW-1:0]       i_rd_addr,
    output cpd_pkg::t_dp_sts    o_sts,
    output cpd_pkg::t_out_beat  o_out_data
);

    localparam int CW = cpd_pkg::COORD_W;
    localparam int DW = cpd_pkg::DIFF_W;
    localparam int SW = cpd_pkg::SQD_W;
    localparam int BW = cpd_pkg::BEST_W;

    logic [cpd_pkg::POINT_W-1:0] w_rd_data;
    logic signed [CW-1:0]        w_rx;
    logic signed [CW-1:0]        w_ry;
    logic signed [CW-1:0]        r_ax;
    logic signed [CW-1:0]        r_ay;
    logic                        r_rd_vld;
    logic                        r_rd_anchor;
    logic                        r_s1_vld;
    logic                        r_s2_vld;
    logic signed [DW-1:0]        r_dx;
    logic signed [DW-1:0]        r_dy;
    logic signed [2*DW-1:0]      w_px;
    logic signed [2*DW-1:0]      w_py;
    logic [SW-1:0]               r_sqx;
    logic [SW-1:0]               r_sqy;
    logic [SW:0]                 w_sum;
    logic [BW-1:0]               r_best;
    logic [cpd_pkg::HALF_W-1:0]  w_root;
    logic                        w_root_done;
    cpd_pkg::t_out_beat          r_out;

    // Point store
    cpd_ram #(
        .WIDTH (cpd_pkg::POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data ({i_in_data.point_x, i_in_data.point_y}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rx = w_rd_data[2*CW-1:CW];
    assign w_ry = w_rd_data[CW-1:0];

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_rd_anchor <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
        end else begin
            r_rd_vld    <= i_cmd.rd_en && !i_cmd.rd_anchor;
            r_rd_anchor <= i_cmd.rd_en && i_cmd.rd_anchor;
            r_s1_vld    <= r_rd_vld;
            r_s2_vld    <= r_s1_vld;
        end
    end

    // Latch anchor point, take differences against it
    always_ff @(posedge i_clk) begin
        if (r_rd_anchor) begin
            r_ax <= w_rx;
            r_ay <= w_ry;
        end
        if (r_rd_vld) begin
            r_dx <= DW'(w_rx) - DW'(r_ax);
            r_dy <= DW'(w_ry) - DW'(r_ay);
        end
    end

    // Square the differences
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_sqx <= w_px[SW-1:0];
            r_sqy <= w_py[SW-1:0];
        end
    end

    // Sum and keep the minimum
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= cpd_pkg::BEST_INIT;
        end else if (i_cmd.clr_best) begin
            r_best <= cpd_pkg::BEST_INIT;
        end else if (r_s2_vld && (BW'(w_sum) < r_best)) begin
            r_best <= BW'(w_sum);
        end
    end

    // Floor square root of the minimum
    cpd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_best),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.no_pair <= i_cmd.out_no_pair;
            if (i_cmd.out_no_pair) begin
                r_out.min_dist_sq   <= '0;
                r_out.half_distance <= '0;
            end else begin
                r_out.min_dist_sq   <= cpd_pkg::SQ_W'(r_best);
                r_out.half_distance <= w_root;
            end
        end
    end

    assign o_out_data      = r_out;
    assign o_sts.pipe_busy = r_rd_vld || r_rd_anchor || r_s1_vld || r_s2_vld;
    assign o_sts.sqrt_done = w_root_done;

endmodule

// ----- rtl/core/cpd_ctrl.sv -----
module cpd_ctrl #(
    parameter int MAX_POINTS = 1024,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_point,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cpd_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    input  cpd_pkg::t_dp_sts  i_sts
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_ANCHOR,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic          r_no_pair;
    logic          r_out_vld;
    logic          w_full;
    logic [CW-1:0] w_count_after;
    logic          w_i_last;
    logic          w_j_last;
    logic          w_out_free;

    assign w_full        = (r_count == CW'(MAX_POINTS));
    assign w_count_after = w_full ? r_count : r_count + 1'b1;
    assign w_i_last      = (r_i == r_j - 1'b1);
    assign w_j_last      = (CW'(r_j) == r_count - 1'b1);
    assign w_out_free    = !r_out_vld || !i_out_stall;

    // Sequence load, pair walk, root and hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_no_pair <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        r_count <= w_count_after;
                        if (i_last_point) begin
                            if (w_count_after < CW'(2)) begin
                                r_no_pair <= 1'b1;
                                r_state   <= S_FINISH;
                            end else begin
                                r_no_pair <= 1'b0;
                                r_j       <= AW'(1);
                                r_state   <= S_ANCHOR;
                            end
                        end
                    end
                end
                S_ANCHOR: begin
                    r_i     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_i_last) begin
                        if (w_j_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ANCHOR;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (i_sts.sqrt_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_count   <= '0;
                        r_state   <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.wr_en       = (r_state == S_LOAD) && i_in_valid && !w_full;
        o_cmd.rd_en       = (r_state == S_ANCHOR) || (r_state == S_SCAN);
        o_cmd.rd_anchor   = (r_state == S_ANCHOR);
        o_cmd.sqrt_start  = (r_state == S_DRAIN) && !i_sts.pipe_busy;
        o_cmd.out_load    = (r_state == S_FINISH) && w_out_free;
        o_cmd.out_no_pair = r_no_pair;
        o_cmd.clr_best    = (r_state == S_FINISH) && w_out_free;
    end

    assign o_wr_addr   = r_count[AW-1:0];
    assign o_rd_addr   = (r_state == S_ANCHOR) ? r_j : r_i;
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_vld;

endmodule

// ----- rtl/core/cpd_checker.sv -----
module cpd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cpd_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cpd_pkg::t_out_beat o_out_data
);

    logic [cpd_pkg::SQ_W:0] w_root_sq;
    logic [cpd_pkg::SQ_W:0] w_root1_sq;

    assign w_root_sq  = (cpd_pkg::SQ_W + 1)'(o_out_data.half_distance)
                      * (cpd_pkg::SQ_W + 1)'(o_out_data.half_distance);
    assign w_root1_sq = ((cpd_pkg::SQ_W + 1)'(o_out_data.half_distance) + 1'b1)
                      * ((cpd_pkg::SQ_W + 1)'(o_out_data.half_distance) + 1'b1);

    // Closing beat stops further input until the set is processed
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last_point |=> o_in_stall)
        else $error("input not held after last point");

    // A fresh result only follows a processing phase
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without processing");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Single point gives zero fields
    a_no_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_pair |->
            o_out_data.min_dist_sq == '0 && o_out_data.half_distance == '0)
        else $error("no_pair with non-zero fields");

    // Root is the floor square root of the minimum
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.no_pair |->
            w_root_sq <= (cpd_pkg::SQ_W + 1)'(o_out_data.min_dist_sq) &&
            w_root1_sq > (cpd_pkg::SQ_W + 1)'(o_out_data.min_dist_sq))
        else $error("root is not the floor square root");

endmodule

bind closest_pair_distance cpd_checker u_cpd_checker (.*);
